// File: design/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the longitudinal speed controller.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SUM_W       = 32;
    localparam int DRV_ACC_W   = 48;

    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_AMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd6;

    localparam logic [1:0] FAULT_SCALE = 2'd1;
    localparam logic [1:0] FAULT_ADD   = 2'd2;

    localparam logic [15:0] SPEED_GAIN_RST  = 16'd9994;
    localparam logic [15:0] ACCEL_GAIN_RST  = 16'd1966;
    localparam logic [15:0] DAMP_GAIN_RST   = 16'd2458;
    localparam logic [16:0] DEADZONE_RST    = 17'd2163;

    localparam logic signed [24:0] ACCEL_STEP  = 25'sd983;
    localparam logic signed [34:0] DRIVE_STEP  = 35'sd492;
    localparam logic signed [32:0] DT_Q32      = 33'sd21474836;
    localparam logic signed [24:0] VERR_LIM    = 25'sd327680;
    localparam logic signed [32:0] BRAKE_RATIO = 33'sd43647;
    localparam logic signed [32:0] DERIV_SCALE = 33'sd200;
    localparam logic signed [32:0] ONE_Q16     = 33'sd65536;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_FAULT,
        ST_FAULT,
        ST_LIMIT,
        ST_MUL_DT,
        ST_TARGET,
        ST_MUL_RECIP,
        ST_QUOT,
        ST_CORR,
        ST_AVG,
        ST_MUL_D200,
        ST_MUL_DG,
        ST_MUL_AG,
        ST_SUM,
        ST_ROUND,
        ST_RATE,
        ST_MAG,
        ST_MUL_BRAKE,
        ST_OUT
    } ctrl_state_t;

endpackage

// File: design/longitudinal_speed_controller.sv
// ----------------------------------------------------------------------------
// longitudinal_speed_controller
// One control tick per input transaction: fault injection, accel rate limit,
// target speed integration, moving-average accel and PD drive with deadzone.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one control tick; the result leaves on
//   m_tvalid/m_tready/m_tdata. cfg_valid/cfg_ready/cfg_index/cfg_data write
//   the tuning registers (cfg_ready is always high); write them while idle.
//   A tick runs through a sequencer around one shared 33x33 multiplier;
//   a new input is taken only once the sequencer is back in idle, after
//   the result has been loaded into the output register. The 100-deep
//   sample window sits in a memory with one write per tick.
//   Reset (aresetn low, synchronous) clears the window via per-entry valid
//   bits, the integrator, the rate limiters and the tick counter, and loads
//   the register defaults; no clearing pass is needed.
//   While m_tready is low the result is held in the output register; the
//   block still accepts and processes the next tick and waits in its last
//   step until the output register is free.
// ----------------------------------------------------------------------------
module longitudinal_speed_controller #(
    parameter int WINDOW_LEN = 100
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // desired_accel, forward_speed, raw_accel_reading
    input  logic [lsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // throttle_cmd, brake_cmd, smoothed_accel, target_speed, zero pad
    output logic [lsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [31:0] RECIP    = 32'((64'd1 << 31) / WINDOW_LEN);
    localparam logic [31:0] HALF_WIN = 32'(WINDOW_LEN / 2);
    localparam logic [32:0] WIN_LEN  = 33'(WINDOW_LEN);

    function automatic logic signed [23:0] sat24(input logic signed [47:0] x);
        if (x > 48'sd8388607) begin
            return 24'sd8388607;
        end else if (x < -48'sd8388608) begin
            return -24'sd8388608;
        end
        return x[23:0];
    endfunction

    lsc_pkg::ctrl_state_t state_reg, state_next;

    // configuration
    logic [1:0]         fault_mode_reg;
    logic signed [20:0] fault_amp_reg;
    logic [31:0]        fault_start_reg;
    logic [15:0]        speed_gain_reg;
    logic [15:0]        accel_gain_reg;
    logic [15:0]        damp_gain_reg;
    logic [16:0]        deadzone_reg;

    // persistent state
    logic signed [lsc_pkg::SUM_W-1:0] win_sum_reg;
    logic [PTR_W-1:0]                 win_ptr_reg;
    logic [WINDOW_LEN-1:0]            win_valid_reg;
    logic signed [23:0]               win_mem [WINDOW_LEN];
    logic signed [23:0]               win_rd_reg;
    logic signed [23:0]               target_reg;
    logic signed [23:0]               last_lim_reg;
    logic signed [19:0]               last_verr_reg;
    logic signed [31:0]               last_drive_reg;
    logic [31:0]                      tick_reg;

    // working registers
    logic signed [23:0]                   accel_reg;
    logic signed [23:0]                   speed_reg;
    logic signed [23:0]                   reading_reg;
    logic signed [lsc_pkg::PROD_W-1:0]    prod_reg;
    logic [31:0]                          n_reg;
    logic                                 neg_sum_reg;
    logic [31:0]                          quot_reg;
    logic signed [23:0]                   avg_reg;
    logic signed [19:0]                   verr_reg;
    logic signed [20:0]                   dverr_reg;
    logic signed [24:0]                   aerr_reg;
    logic signed [lsc_pkg::DRV_ACC_W-1:0] acc_reg;
    logic signed [33:0]                   draw_reg;
    logic [31:0]                          dmag_reg;
    logic [17:0]                          bmag_reg;
    logic                                 m_tvalid_reg;
    logic [lsc_pkg::OUT_TDATA_W-1:0]      m_tdata_reg;

    logic signed [lsc_pkg::MUL_W-1:0] mul_a, mul_b;

    logic                   fault_on;
    logic signed [47:0]     scale_rnd;
    logic signed [23:0]     accel_fault;
    logic signed [24:0]     acc_delta;
    logic signed [24:0]     lim_wide;
    logic signed [51:0]     dt_rnd;
    logic signed [25:0]     tgt_sum;
    logic signed [24:0]     verr_diff;
    logic signed [19:0]     verr_sat;
    logic signed [23:0]     fwd;
    logic signed [23:0]     win_old;
    logic signed [31:0]     win_sum_next;
    logic [31:0]            sum_mag;
    logic [32:0]            rem;
    logic signed [lsc_pkg::DRV_ACC_W-1:0] acc_rnd;
    logic signed [34:0]     drv_delta;
    logic signed [34:0]     drv_lim;
    logic signed [31:0]     drv_sat;
    logic signed [32:0]     drv_neg;
    logic signed [47:0]     brk_rnd;
    logic [16:0]            brk_cmd;
    logic [16:0]            thr_cmd;
    logic                   in_dead;
    logic                   out_free;

    assign s_tready  = (state_reg == lsc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            lsc_pkg::ST_MUL_FAULT: begin
                mul_a = 33'(accel_reg);
                mul_b = lsc_pkg::ONE_Q16 + 33'(fault_amp_reg);
            end
            lsc_pkg::ST_MUL_DT: begin
                mul_a = 33'(last_lim_reg);
                mul_b = lsc_pkg::DT_Q32;
            end
            lsc_pkg::ST_MUL_RECIP: begin
                mul_a = $signed({1'b0, n_reg});
                mul_b = $signed({1'b0, RECIP});
            end
            lsc_pkg::ST_QUOT: begin
                mul_a = $signed({1'b0, prod_reg[62:31]});
                mul_b = $signed(WIN_LEN);
            end
            lsc_pkg::ST_AVG: begin
                mul_a = $signed({17'd0, speed_gain_reg});
                mul_b = 33'(verr_reg);
            end
            lsc_pkg::ST_MUL_D200: begin
                mul_a = 33'(dverr_reg);
                mul_b = lsc_pkg::DERIV_SCALE;
            end
            lsc_pkg::ST_MUL_DG: begin
                mul_a = prod_reg[32:0];
                mul_b = $signed({17'd0, damp_gain_reg});
            end
            lsc_pkg::ST_MUL_AG: begin
                mul_a = $signed({17'd0, accel_gain_reg});
                mul_b = 33'(aerr_reg);
            end
            default: begin
                mul_a = $signed({15'd0, bmag_reg});
                mul_b = lsc_pkg::BRAKE_RATIO;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        fault_on  = (fault_start_reg != 32'hFFFF_FFFF) && (tick_reg >= fault_start_reg);
        scale_rnd = ($signed(prod_reg[47:0]) + 48'sd32768) >>> 16;
        accel_fault = accel_reg;
        if (fault_on) begin
            if (fault_mode_reg == lsc_pkg::FAULT_SCALE) begin
                accel_fault = sat24(scale_rnd);
            end else if (fault_mode_reg == lsc_pkg::FAULT_ADD) begin
                accel_fault = sat24(48'(accel_reg) + 48'(fault_amp_reg));
            end
        end

        acc_delta = 25'(accel_reg) - 25'(last_lim_reg);
        if (acc_delta > lsc_pkg::ACCEL_STEP) begin
            lim_wide = 25'(last_lim_reg) + lsc_pkg::ACCEL_STEP;
        end else if (acc_delta < -lsc_pkg::ACCEL_STEP) begin
            lim_wide = 25'(last_lim_reg) - lsc_pkg::ACCEL_STEP;
        end else begin
            lim_wide = 25'(accel_reg);
        end

        dt_rnd  = ($signed(prod_reg[51:0]) + 52'sd2147483648) >>> 32;
        tgt_sum = 26'(target_reg) + 26'(dt_rnd);

        verr_diff = 25'(target_reg) - 25'(speed_reg);
        if (verr_diff > lsc_pkg::VERR_LIM) begin
            verr_sat = 20'(lsc_pkg::VERR_LIM);
        end else if (verr_diff < -lsc_pkg::VERR_LIM) begin
            verr_sat = 20'(-lsc_pkg::VERR_LIM);
        end else begin
            verr_sat = verr_diff[19:0];
        end

        fwd = (reading_reg == -24'sd8388608) ? 24'sd8388607 : -reading_reg;
        win_old = win_valid_reg[win_ptr_reg] ? win_rd_reg : 24'sd0;
        win_sum_next = win_sum_reg + 32'(fwd) - 32'(win_old);
        sum_mag = win_sum_reg[31] ? 32'(-win_sum_reg) : 32'(win_sum_reg);

        rem = {1'b0, n_reg} - prod_reg[32:0];

        acc_rnd = (acc_reg + 48'sd8192) >>> 14;

        drv_delta = 35'(draw_reg) - 35'(last_drive_reg);
        if (drv_delta > lsc_pkg::DRIVE_STEP) begin
            drv_lim = 35'(last_drive_reg) + lsc_pkg::DRIVE_STEP;
        end else if (drv_delta < -lsc_pkg::DRIVE_STEP) begin
            drv_lim = 35'(last_drive_reg) - lsc_pkg::DRIVE_STEP;
        end else begin
            drv_lim = 35'(draw_reg);
        end
        if (drv_lim > 35'sd2147483647) begin
            drv_sat = 32'sh7FFF_FFFF;
        end else if (drv_lim < -35'sd2147483648) begin
            drv_sat = 32'sh8000_0000;
        end else begin
            drv_sat = drv_lim[31:0];
        end

        drv_neg = -33'(last_drive_reg);

        brk_rnd = (prod_reg[47:0] + 48'sd32768) >>> 16;
        if (brk_rnd > 48'sd65536) begin
            brk_cmd = 17'd65536;
        end else if (brk_rnd < 48'sd0) begin
            brk_cmd = 17'd0;
        end else begin
            brk_cmd = brk_rnd[16:0];
        end
        if (last_drive_reg > 32'sd65536) begin
            thr_cmd = 17'd65536;
        end else if (last_drive_reg < 32'sd0) begin
            thr_cmd = 17'd0;
        end else begin
            thr_cmd = last_drive_reg[16:0];
        end
        in_dead = (dmag_reg < 32'(deadzone_reg));
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsc_pkg::ST_IDLE:      if (s_tvalid) state_next = lsc_pkg::ST_MUL_FAULT;
            lsc_pkg::ST_MUL_FAULT: state_next = lsc_pkg::ST_FAULT;
            lsc_pkg::ST_FAULT:     state_next = lsc_pkg::ST_LIMIT;
            lsc_pkg::ST_LIMIT:     state_next = lsc_pkg::ST_MUL_DT;
            lsc_pkg::ST_MUL_DT:    state_next = lsc_pkg::ST_TARGET;
            lsc_pkg::ST_TARGET:    state_next = lsc_pkg::ST_MUL_RECIP;
            lsc_pkg::ST_MUL_RECIP: state_next = lsc_pkg::ST_QUOT;
            lsc_pkg::ST_QUOT:      state_next = lsc_pkg::ST_CORR;
            lsc_pkg::ST_CORR:      state_next = lsc_pkg::ST_AVG;
            lsc_pkg::ST_AVG:       state_next = lsc_pkg::ST_MUL_D200;
            lsc_pkg::ST_MUL_D200:  state_next = lsc_pkg::ST_MUL_DG;
            lsc_pkg::ST_MUL_DG:    state_next = lsc_pkg::ST_MUL_AG;
            lsc_pkg::ST_MUL_AG:    state_next = lsc_pkg::ST_SUM;
            lsc_pkg::ST_SUM:       state_next = lsc_pkg::ST_ROUND;
            lsc_pkg::ST_ROUND:     state_next = lsc_pkg::ST_RATE;
            lsc_pkg::ST_RATE:      state_next = lsc_pkg::ST_MAG;
            lsc_pkg::ST_MAG:       state_next = lsc_pkg::ST_MUL_BRAKE;
            lsc_pkg::ST_MUL_BRAKE: state_next = lsc_pkg::ST_OUT;
            lsc_pkg::ST_OUT:       if (out_free) state_next = lsc_pkg::ST_IDLE;
            default:               state_next = lsc_pkg::ST_IDLE;
        endcase
    end

    // sample window memory
    always_ff @(posedge aclk) begin
        if (state_reg == lsc_pkg::ST_MUL_DT) begin
            win_mem[win_ptr_reg] <= fwd;
        end
        win_rd_reg <= win_mem[win_ptr_reg];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_mode_reg  <= 2'd0;
            fault_amp_reg   <= 21'sd0;
            fault_start_reg <= 32'hFFFF_FFFF;
            speed_gain_reg  <= lsc_pkg::SPEED_GAIN_RST;
            accel_gain_reg  <= lsc_pkg::ACCEL_GAIN_RST;
            damp_gain_reg   <= lsc_pkg::DAMP_GAIN_RST;
            deadzone_reg    <= lsc_pkg::DEADZONE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lsc_pkg::REG_FAULT_MODE:  fault_mode_reg  <= cfg_data[1:0];
                lsc_pkg::REG_FAULT_AMP:   fault_amp_reg   <= $signed(cfg_data[20:0]);
                lsc_pkg::REG_FAULT_START: fault_start_reg <= cfg_data;
                lsc_pkg::REG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[15:0];
                lsc_pkg::REG_ACCEL_GAIN:  accel_gain_reg  <= cfg_data[15:0];
                lsc_pkg::REG_DAMP_GAIN:   damp_gain_reg   <= cfg_data[15:0];
                lsc_pkg::REG_DEADZONE:    deadzone_reg    <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            win_sum_reg    <= '0;
            win_ptr_reg    <= '0;
            win_valid_reg  <= '0;
            target_reg     <= '0;
            last_lim_reg   <= '0;
            last_verr_reg  <= '0;
            last_drive_reg <= '0;
            tick_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != lsc_pkg::ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lsc_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        accel_reg   <= $signed(s_tdata[23:0]);
                        speed_reg   <= $signed(s_tdata[47:24]);
                        reading_reg <= $signed(s_tdata[71:48]);
                    end
                end
                lsc_pkg::ST_FAULT: begin
                    accel_reg <= accel_fault;
                    if (tick_reg != 32'hFFFF_FFFF) begin
                        tick_reg <= tick_reg + 32'd1;
                    end
                end
                lsc_pkg::ST_LIMIT: begin
                    last_lim_reg <= lim_wide[23:0];
                end
                lsc_pkg::ST_MUL_DT: begin
                    win_sum_reg <= win_sum_next;
                    win_valid_reg[win_ptr_reg] <= 1'b1;
                    win_ptr_reg <= (win_ptr_reg == PTR_W'(WINDOW_LEN - 1)) ?
                                   '0 : win_ptr_reg + 1'b1;
                end
                lsc_pkg::ST_TARGET: begin
                    target_reg  <= sat24(48'(tgt_sum));
                    n_reg       <= sum_mag + HALF_WIN;
                    neg_sum_reg <= win_sum_reg[31];
                end
                lsc_pkg::ST_MUL_RECIP: begin
                    verr_reg <= verr_sat;
                end
                lsc_pkg::ST_QUOT: begin
                    quot_reg <= prod_reg[62:31];
                end
                lsc_pkg::ST_CORR: begin
                    if (rem >= WIN_LEN) begin
                        quot_reg <= quot_reg + 32'd1;
                    end
                end
                lsc_pkg::ST_AVG: begin
                    avg_reg       <= neg_sum_reg ? -$signed(quot_reg[23:0]) :
                                                   $signed(quot_reg[23:0]);
                    dverr_reg     <= 21'(verr_reg) - 21'(last_verr_reg);
                    last_verr_reg <= verr_reg;
                end
                lsc_pkg::ST_MUL_D200: begin
                    acc_reg  <= prod_reg[47:0];
                    aerr_reg <= 25'(last_lim_reg) - 25'(avg_reg);
                end
                lsc_pkg::ST_MUL_AG: begin
                    acc_reg <= acc_reg + prod_reg[47:0];
                end
                lsc_pkg::ST_SUM: begin
                    acc_reg <= acc_reg + prod_reg[47:0];
                end
                lsc_pkg::ST_ROUND: begin
                    draw_reg <= acc_rnd[33:0];
                end
                lsc_pkg::ST_RATE: begin
                    last_drive_reg <= drv_sat;
                end
                lsc_pkg::ST_MAG: begin
                    dmag_reg <= last_drive_reg[31] ? drv_neg[31:0] : last_drive_reg;
                    if (!last_drive_reg[31]) begin
                        bmag_reg <= '0;
                    end else if (drv_neg > 33'sd131072) begin
                        bmag_reg <= 18'd131072;
                    end else begin
                        bmag_reg <= drv_neg[17:0];
                    end
                end
                lsc_pkg::ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, target_reg, avg_reg,
                                         in_dead ? 17'd0 : brk_cmd,
                                         in_dead ? 17'd0 : thr_cmd};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
